>>> sv/rscl_pkg.sv
// ----------------------------------------------------------------------------
// rscl_pkg
// Shared types, constants and helpers for the ray/sphere closest-hit unit.
// ----------------------------------------------------------------------------
package rscl_pkg;

    localparam int MAX_SPHERES_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRACE = 1'b1;

    // largest normal magnitude that fits the 18-bit signed result
    localparam logic [16:0] NRM_MAX = 17'h1ffff;

    typedef struct packed {
        logic        op;
        logic [3:0]  idx;
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] v2;
        logic [31:0] v3;
        logic [31:0] v4;
        logic [31:0] v5;
    } cmd_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] distance;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [17:0] normal_x;
        logic [17:0] normal_y;
        logic [17:0] normal_z;
        logic [3:0]  object_index;
    } res_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_A_MUL,
        ST_FETCH,
        ST_OC,
        ST_H_MUL,
        ST_C_MUL,
        ST_D_MUL,
        ST_SQRT,
        ST_DIV,
        ST_NEXT,
        ST_FIN,
        ST_POS,
        ST_NRM,
        ST_LEN,
        ST_LSQRT,
        ST_NDIV,
        ST_NWAIT,
        ST_OUT
    } bk_state_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

>>> sv/rscl_fifo.sv
// ----------------------------------------------------------------------------
// rscl_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module rscl_fifo
    import rscl_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNTW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        if (do_push && !do_pop)
            cnt_next = CNTW'(cnt_reg + 1'b1);
        else if (do_pop && !do_push)
            cnt_next = CNTW'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

endmodule

>>> sv/rscl_front.sv
// ----------------------------------------------------------------------------
// rscl_front
// Input side: classifies load and trace items, drops loads to missing slots.
// ----------------------------------------------------------------------------
module rscl_front
    import rscl_pkg::*;
#(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF
)
(
    input  logic               push,
    input  logic               full,
    input  logic               op,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [30:0]        radius,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    output cmd_t               cmd,
    output logic               cmd_push
);

    logic keep;

    assign keep     = (op == OP_TRACE) || (32'(entry_index) < 32'(MAX_SPHERES));
    assign cmd_push = push && !full && keep;

    always_comb
    begin
        cmd.op  = op;
        cmd.idx = entry_index;
        if (op == OP_LOAD)
        begin
            cmd.v0 = center_x;
            cmd.v1 = center_y;
            cmd.v2 = center_z;
            cmd.v3 = {1'b0, radius};
            cmd.v4 = '0;
            cmd.v5 = '0;
        end
        else
        begin
            cmd.v0 = origin_x;
            cmd.v1 = origin_y;
            cmd.v2 = origin_z;
            cmd.v3 = dir_x;
            cmd.v4 = dir_y;
            cmd.v5 = dir_z;
        end
    end

endmodule

>>> sv/rscl_isqrt.sv
// ----------------------------------------------------------------------------
// rscl_isqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module rscl_isqrt
    import rscl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] val,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg, busy_next, done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] val_reg, val_next;
    logic [34:0] rem_reg, rem_next, rem_t, trial;
    logic [31:0] root_reg, root_next;

    assign done  = done_reg;
    assign root  = root_reg;
    assign rem_t = {rem_reg[32:0], val_reg[63:62]};
    assign trial = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = val;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[61:0], 2'b00};
            cnt_next = 5'(cnt_reg + 1'b1);
            if (rem_t >= trial)
            begin
                rem_next  = rem_t - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_t;
                root_next = {root_reg[30:0], 1'b0};
            end
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

endmodule

>>> sv/rscl_div.sv
// ----------------------------------------------------------------------------
// rscl_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rscl_div
    import rscl_pkg::*;
#(
    parameter int NUM_W = 48,
    parameter int DEN_W = 33
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CW = $clog2(NUM_W);

    logic             busy_reg, busy_next, done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next, quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next, rem_reg, rem_next;
    logic [DEN_W:0]   rem_t;

    assign done  = done_reg;
    assign quo   = quo_reg;
    assign rem_t = {rem_reg, num_reg[NUM_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            cnt_next = CW'(cnt_reg + 1'b1);
            if (rem_t >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(rem_t - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_t[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            if (cnt_reg == CW'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

>>> sv/rscl_back.sv
// ----------------------------------------------------------------------------
// rscl_back
// Execution side: sphere table, shared multiplier sequencer, square root and
// divider, result build.
// ----------------------------------------------------------------------------
module rscl_back
    import rscl_pkg::*;
#(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [4:0] cfg_wr_data,
    input  cmd_t       cmd,
    input  logic       cmd_empty,
    output logic       cmd_pop,
    output res_t       res,
    input  logic       res_full,
    output logic       res_push
);

    localparam int AW    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CW    = $clog2(MAX_SPHERES + 1);
    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int DEN_W = 33;

    logic signed [31:0] mem_cx [MAX_SPHERES];
    logic signed [31:0] mem_cy [MAX_SPHERES];
    logic signed [31:0] mem_cz [MAX_SPHERES];
    logic [30:0]        mem_r  [MAX_SPHERES];

    bk_state_t          state_reg, state_next;
    logic [2:0]         cnt_reg, cnt_next, last;
    logic [CW-1:0]      sph_reg, sph_next, lim;
    logic [4:0]         count_reg;
    logic signed [31:0] o_reg [3], o_next [3], d_reg [3], d_next [3];
    logic signed [31:0] oc_reg [3], oc_next [3], pos_reg [3], pos_next [3];
    logic signed [31:0] n_reg [3], n_next [3], bc_reg [3], bc_next [3];
    logic signed [31:0] ent_c_reg [3];
    logic [30:0]        ent_r_reg;
    logic signed [31:0] a_reg, a_next, h_reg, h_next, c_reg, c_next;
    logic signed [65:0] acc_reg, acc_next, acc_sum, prod_reg, term;
    logic signed [32:0] ma, mb;
    logic               any_reg, any_next, sub, at_last, mem_we;
    logic [30:0]        bt_reg, bt_next, t_sat;
    logic [AW-1:0]      bi_reg, bi_next;
    logic [31:0]        len_reg, len_next, mag;
    logic [17:0]        nrm_reg [3], nrm_next [3];
    logic [16:0]        q_nrm;
    res_t               res_reg, res_next;
    logic [1:0]         k, fk;
    logic               t_win;
    logic signed [33:0] num;
    logic               sq_start, sq_done, dv_start, dv_done;
    logic [31:0]        sq_root;
    logic [NUM_W-1:0]   dv_num, dv_q;
    logic [DEN_W-1:0]   dv_den;

    function automatic logic signed [31:0] pick3(input logic signed [31:0] v0,
                                                 input logic signed [31:0] v1,
                                                 input logic signed [31:0] v2,
                                                 input logic [1:0] sel);
        logic signed [31:0] r;
        unique case (sel)
            2'd0:    r = v0;
            2'd1:    r = v1;
            2'd2:    r = v2;
            default: r = '0;
        endcase
        return r;
    endfunction

    rscl_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .val   (acc_sum[63:0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    rscl_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quo   (dv_q)
    );

    assign res = res_reg;
    assign k   = cnt_reg[1:0];
    assign fk  = 2'(cnt_reg - 3'd1);

    always_comb
    begin
        if (32'(count_reg) > 32'(MAX_SPHERES))
            lim = CW'(MAX_SPHERES);
        else
            lim = CW'(count_reg);
    end

    always_comb
    begin
        unique case (state_reg)
            ST_A_MUL, ST_H_MUL, ST_LEN, ST_POS: last = 3'd3;
            ST_C_MUL:                           last = 3'd4;
            ST_D_MUL:                           last = 3'd2;
            default:                            last = 3'd0;
        endcase
    end
    assign at_last = (cnt_reg == last);

    // shared multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            ST_A_MUL:
            begin
                ma = 33'(pick3(d_reg[0], d_reg[1], d_reg[2], k));
                mb = ma;
            end
            ST_H_MUL:
            begin
                ma = 33'(pick3(d_reg[0], d_reg[1], d_reg[2], k));
                mb = 33'(pick3(oc_reg[0], oc_reg[1], oc_reg[2], k));
            end
            ST_C_MUL:
            begin
                if (k == 2'd3)
                    ma = $signed({2'b00, ent_r_reg});
                else
                    ma = 33'(pick3(oc_reg[0], oc_reg[1], oc_reg[2], k));
                mb = ma;
            end
            ST_D_MUL:
            begin
                if (k == 2'd0)
                begin
                    ma = 33'(h_reg);
                    mb = 33'(h_reg);
                end
                else
                begin
                    ma = 33'(a_reg);
                    mb = 33'(c_reg);
                end
            end
            ST_POS:
            begin
                ma = $signed({2'b00, bt_reg});
                mb = 33'(pick3(d_reg[0], d_reg[1], d_reg[2], k));
            end
            ST_LEN:
            begin
                ma = 33'(pick3(n_reg[0], n_reg[1], n_reg[2], k));
                mb = ma;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_D_MUL || state_reg == ST_LEN)
            term = prod_reg;
        else
            term = prod_reg >>> FRAC_BITS;
        sub = ((state_reg == ST_C_MUL) && (fk == 2'd3)) ||
              ((state_reg == ST_D_MUL) && (fk == 2'd1));
        if (cnt_reg == '0)
            acc_sum = '0;
        else if (sub)
            acc_sum = acc_reg - term;
        else
            acc_sum = acc_reg + term;
    end

    // near root numerator -h - sqrt(disc)
    assign num   = -34'(h_reg) - $signed({2'b00, sq_root});
    assign t_sat = (|dv_q[NUM_W-1:31]) ? '1 : dv_q[30:0];
    assign t_win = !any_reg || (t_sat <= bt_reg);
    assign q_nrm = (|dv_q[NUM_W-1:17]) ? NRM_MAX : dv_q[16:0];

    always_comb
    begin
        logic signed [31:0] nk;
        nk  = pick3(n_reg[0], n_reg[1], n_reg[2], k);
        mag = nk[31] ? 32'(-33'(nk)) : 32'(nk);
    end

    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            dv_num = {num[31:0], {FRAC_BITS{1'b0}}};
            dv_den = {2'b00, a_reg[30:0]};
        end
        else
        begin
            dv_num = {mag, {FRAC_BITS{1'b0}}};
            dv_den = {1'b0, len_reg};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (!cmd_empty && cmd.op == OP_TRACE)
                    state_next = ST_A_MUL;
            ST_A_MUL:
                if (at_last)
                begin
                    if (sat32(acc_sum) == '0)
                        state_next = ST_OUT;
                    else if (lim == '0)
                        state_next = ST_FIN;
                    else
                        state_next = ST_FETCH;
                end
            ST_FETCH: state_next = ST_OC;
            ST_OC:    state_next = ST_H_MUL;
            ST_H_MUL:
                if (at_last)
                    state_next = ST_C_MUL;
            ST_C_MUL:
                if (at_last)
                    state_next = ST_D_MUL;
            ST_D_MUL:
                if (at_last)
                    state_next = acc_sum[65] ? ST_NEXT : ST_SQRT;
            ST_SQRT:
                if (sq_done)
                    state_next = num[33] ? ST_NEXT : ST_DIV;
            ST_DIV:
                if (dv_done)
                    state_next = ST_NEXT;
            ST_NEXT:
                state_next = (CW'(sph_reg + 1'b1) == lim) ? ST_FIN : ST_FETCH;
            ST_FIN:
                state_next = (!any_reg || bt_reg == '0) ? ST_OUT : ST_POS;
            ST_POS:
                if (at_last)
                    state_next = ST_NRM;
            ST_NRM:   state_next = ST_LEN;
            ST_LEN:
                if (at_last)
                    state_next = ST_LSQRT;
            ST_LSQRT:
                if (sq_done)
                    state_next = ST_NDIV;
            ST_NDIV:
                if (cnt_reg == 3'd3)
                    state_next = ST_OUT;
                else if (len_reg != '0)
                    state_next = ST_NWAIT;
            ST_NWAIT:
                if (dv_done)
                    state_next = ST_NDIV;
            ST_OUT:
                if (!res_full)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty;
        mem_we   = cmd_pop && (cmd.op == OP_LOAD);
        sq_start = ((state_reg == ST_D_MUL) && at_last && !acc_sum[65]) ||
                   ((state_reg == ST_LEN) && at_last);
        dv_start = ((state_reg == ST_SQRT) && sq_done && !num[33]) ||
                   ((state_reg == ST_NDIV) && (cnt_reg != 3'd3) && (len_reg != '0));
        res_push = (state_reg == ST_OUT);
    end

    // datapath
    always_comb
    begin
        cnt_next = cnt_reg;
        sph_next = sph_reg;
        any_next = any_reg;
        bt_next  = bt_reg;
        bi_next  = bi_reg;
        a_next   = a_reg;
        h_next   = h_reg;
        c_next   = c_reg;
        acc_next = acc_reg;
        len_next = len_reg;
        res_next = res_reg;
        for (int i = 0; i < 3; i++)
        begin
            o_next[i]   = o_reg[i];
            d_next[i]   = d_reg[i];
            oc_next[i]  = oc_reg[i];
            pos_next[i] = pos_reg[i];
            n_next[i]   = n_reg[i];
            bc_next[i]  = bc_reg[i];
            nrm_next[i] = nrm_reg[i];
        end
        unique case (state_reg)
            ST_IDLE:
                if (cmd_pop && cmd.op == OP_TRACE)
                begin
                    o_next[0] = cmd.v0;
                    o_next[1] = cmd.v1;
                    o_next[2] = cmd.v2;
                    d_next[0] = cmd.v3;
                    d_next[1] = cmd.v4;
                    d_next[2] = cmd.v5;
                    cnt_next  = '0;
                    sph_next  = '0;
                    any_next  = 1'b0;
                    bt_next   = '0;
                    bi_next   = '0;
                end
            ST_A_MUL, ST_H_MUL, ST_C_MUL, ST_D_MUL, ST_LEN:
            begin
                acc_next = acc_sum;
                cnt_next = at_last ? 3'd0 : 3'(cnt_reg + 1'b1);
                if (at_last)
                begin
                    unique case (state_reg)
                        ST_A_MUL:
                        begin
                            a_next   = sat32(acc_sum);
                            res_next = '0;
                        end
                        ST_H_MUL: h_next = sat32(acc_sum);
                        ST_C_MUL: c_next = sat32(acc_sum);
                        default:  acc_next = acc_sum;
                    endcase
                end
            end
            ST_OC:
                for (int i = 0; i < 3; i++)
                    oc_next[i] = sat32(66'(o_reg[i]) - 66'(ent_c_reg[i]));
            ST_DIV:
                if (dv_done && t_win)
                begin
                    bt_next  = t_sat;
                    bi_next  = sph_reg[AW-1:0];
                    any_next = 1'b1;
                    for (int i = 0; i < 3; i++)
                        bc_next[i] = ent_c_reg[i];
                end
            ST_NEXT:
                sph_next = CW'(sph_reg + 1'b1);
            ST_FIN:
            begin
                cnt_next = '0;
                res_next = '0;
            end
            ST_POS:
            begin
                cnt_next = at_last ? 3'd0 : 3'(cnt_reg + 1'b1);
                if (cnt_reg != '0)
                    for (int i = 0; i < 3; i++)
                        if (fk == 2'(i))
                            pos_next[i] = sat32(term + 66'(o_reg[i]));
            end
            ST_NRM:
                for (int i = 0; i < 3; i++)
                    n_next[i] = sat32(66'(pos_reg[i]) - 66'(bc_reg[i]));
            ST_LSQRT:
                if (sq_done)
                begin
                    len_next = sq_root;
                    cnt_next = '0;
                end
            ST_NDIV:
                if (cnt_reg == 3'd3)
                begin
                    res_next.hit          = 1'b1;
                    res_next.distance     = bt_reg;
                    res_next.pos_x        = pos_reg[0];
                    res_next.pos_y        = pos_reg[1];
                    res_next.pos_z        = pos_reg[2];
                    res_next.normal_x     = nrm_reg[0];
                    res_next.normal_y     = nrm_reg[1];
                    res_next.normal_z     = nrm_reg[2];
                    res_next.object_index = 4'(bi_reg);
                end
                else if (len_reg == '0)
                begin
                    // degenerate normal
                    for (int i = 0; i < 3; i++)
                        if (k == 2'(i))
                            nrm_next[i] = '0;
                    cnt_next = 3'(cnt_reg + 1'b1);
                end
            ST_NWAIT:
                if (dv_done)
                begin
                    for (int i = 0; i < 3; i++)
                        if (k == 2'(i))
                            nrm_next[i] = n_reg[i][31] ? 18'(-{1'b0, q_nrm})
                                                       : {1'b0, q_nrm};
                    cnt_next = 3'(cnt_reg + 1'b1);
                end
            default:
                cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sph_reg   <= '0;
            any_reg   <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sph_reg   <= sph_next;
            any_reg   <= any_next;
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        acc_reg  <= acc_next;
        a_reg    <= a_next;
        h_reg    <= h_next;
        c_reg    <= c_next;
        bt_reg   <= bt_next;
        bi_reg   <= bi_next;
        len_reg  <= len_next;
        res_reg  <= res_next;
        for (int i = 0; i < 3; i++)
        begin
            o_reg[i]   <= o_next[i];
            d_reg[i]   <= d_next[i];
            oc_reg[i]  <= oc_next[i];
            pos_reg[i] <= pos_next[i];
            n_reg[i]   <= n_next[i];
            bc_reg[i]  <= bc_next[i];
            nrm_reg[i] <= nrm_next[i];
        end
    end

    // sphere table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_cx[AW'(cmd.idx)] <= cmd.v0;
            mem_cy[AW'(cmd.idx)] <= cmd.v1;
            mem_cz[AW'(cmd.idx)] <= cmd.v2;
            mem_r[AW'(cmd.idx)]  <= cmd.v3[30:0];
        end
        if (state_reg == ST_FETCH)
        begin
            ent_c_reg[0] <= mem_cx[sph_reg[AW-1:0]];
            ent_c_reg[1] <= mem_cy[sph_reg[AW-1:0]];
            ent_c_reg[2] <= mem_cz[sph_reg[AW-1:0]];
            ent_r_reg    <= mem_r[sph_reg[AW-1:0]];
        end
    end

endmodule

>>> sv/ray_sphere_closest_hit.sv
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit
// Ray/sphere closest-hit unit with a loadable sphere table.
// ----------------------------------------------------------------------------
// Load transactions (op 0) fill the sphere table and give no result; trace
// transactions (op 1) give one result. A load is written to the table as
// the back end pops it. The run time of a trace is set by the shared
// bit-serial square root and the shared restoring divider that the spheres
// and, when there is a hit, the normal components go through; a sphere whose
// discriminant is negative skips both. Two-entry queues sit on the input and
// result sides, so new transactions are taken while a result waits.
module ray_sphere_closest_hit
    import rscl_pkg::*;
#(
    parameter int MAX_SPHERES = MAX_SPHERES_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    input  logic               push,
    output logic               full,
    input  logic               op,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] center_x,
    input  logic signed [31:0] center_y,
    input  logic signed [31:0] center_z,
    input  logic [30:0]        radius,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    output logic               empty,
    input  logic               pop,
    output logic               hit,
    output logic [30:0]        distance,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [17:0] normal_x,
    output logic signed [17:0] normal_y,
    output logic signed [17:0] normal_z,
    output logic [3:0]         object_index
);

    cmd_t cmd_in, cmd_out;
    logic cmd_push, cmd_empty, cmd_pop;
    res_t res_in, res_out;
    logic res_push, res_full;

    rscl_front #(
        .MAX_SPHERES (MAX_SPHERES)
    ) u_front (
        .push        (push),
        .full        (full),
        .op          (op),
        .entry_index (entry_index),
        .center_x    (center_x),
        .center_y    (center_y),
        .center_z    (center_z),
        .radius      (radius),
        .origin_x    (origin_x),
        .origin_y    (origin_y),
        .origin_z    (origin_z),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .dir_z       (dir_z),
        .cmd         (cmd_in),
        .cmd_push    (cmd_push)
    );

    rscl_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty)
    );

    rscl_back #(
        .MAX_SPHERES (MAX_SPHERES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_out),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop),
        .res         (res_in),
        .res_full    (res_full),
        .res_push    (res_push)
    );

    rscl_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign hit          = res_out.hit;
    assign distance     = res_out.distance;
    assign pos_x        = res_out.pos_x;
    assign pos_y        = res_out.pos_y;
    assign pos_z        = res_out.pos_z;
    assign normal_x     = res_out.normal_x;
    assign normal_y     = res_out.normal_y;
    assign normal_z     = res_out.normal_z;
    assign object_index = res_out.object_index;

endmodule

>>> sv/rscl_checker.sv
// ----------------------------------------------------------------------------
// rscl_checker
// Port-level checks on the result side of the closest-hit unit.
// ----------------------------------------------------------------------------
module rscl_checker
    import rscl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic               hit,
    input logic [30:0]        distance,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic signed [31:0] pos_z,
    input logic signed [17:0] normal_x,
    input logic signed [17:0] normal_y,
    input logic signed [17:0] normal_z,
    input logic [3:0]         object_index
);

    // a waiting result holds until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(hit) && $stable(distance) &&
        $stable(object_index))
        else $error("result changed while waiting");

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !hit |-> distance == '0 && object_index == '0 &&
        pos_x == '0 && pos_y == '0 && pos_z == '0 &&
        normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("miss with nonzero fields");

    // a hit is at a positive distance
    a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && hit |-> distance != '0)
        else $error("hit at zero distance");

    // normal components are saturated symmetric
    a_nrm_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> normal_x != 18'sh20000 && normal_y != 18'sh20000 &&
        normal_z != 18'sh20000)
        else $error("normal outside saturation range");

endmodule

bind ray_sphere_closest_hit rscl_checker u_rscl_checker (.*);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray/sphere closest-hit unit. Loads sphere
// tables, traces rays through them under several sphere counts and handshake
// pressure levels, and compares every result against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top
    import rscl_pkg::*;
;

    localparam int NSPH = 16;
    localparam int FB   = 16;
    localparam longint S32MAX = 64'sd2147483647;
    localparam longint S32MIN = -64'sd2147483648;

    typedef struct {
        logic        op;
        logic [3:0]  idx;
        logic [31:0] c0, c1, c2;
        logic [30:0] rad;
        logic [31:0] o0, o1, o2;
        logic [31:0] d0, d1, d2;
    } xact_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [4:0] cfg_wr_data = '0;
    logic push = 0;
    logic pop = 0;
    logic full, empty;
    xact_t cur = '{default: '0};
    logic hit;
    logic [30:0] distance;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [17:0] normal_x, normal_y, normal_z;
    logic [3:0] object_index;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    ray_sphere_closest_hit u_top (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .push(push), .full(full), .op(cur.op), .entry_index(cur.idx),
        .center_x(cur.c0), .center_y(cur.c1), .center_z(cur.c2), .radius(cur.rad),
        .origin_x(cur.o0), .origin_y(cur.o1), .origin_z(cur.o2),
        .dir_x(cur.d0), .dir_y(cur.d1), .dir_z(cur.d2),
        .empty(empty), .pop(pop), .hit(hit), .distance(distance),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .object_index(object_index)
    );

    // predictor state
    longint tbl_cx[NSPH], tbl_cy[NSPH], tbl_cz[NSPH], tbl_r[NSPH];
    int unsigned active_count = 0;

    xact_t pending[$];
    res_t  hit_expect[$];
    int idle_pct = 0, stall_pct = 0;
    int errors = 0, mismatches = 0, traces = 0, hits_seen = 0;
    longint cycles = 0;

    function automatic longint clamp32(longint v);
        if (v > S32MAX) return S32MAX;
        if (v < S32MIN) return S32MIN;
        return v;
    endfunction

    function automatic longint fshr(longint v);
        return v >>> FB;
    endfunction

    // floor square root of a 64-bit unsigned value
    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned sqf(longint v);
        longint unsigned p;
        p = v * v;
        return p >> FB;
    endfunction

    function automatic res_t trace_ray(xact_t x);
        res_t res;
        longint o[3], d[3], oc[3], pos[3], n[3], cen[3];
        longint a, h, c, disc, num;
        longint unsigned s, t, best_t, len, mag, q;
        int cnt, best_i;
        bit any;
        res = '0;
        best_t = 0;
        best_i = 0;
        any = 0;
        o[0] = $signed(x.o0); o[1] = $signed(x.o1); o[2] = $signed(x.o2);
        d[0] = $signed(x.d0); d[1] = $signed(x.d1); d[2] = $signed(x.d2);
        a = clamp32(longint'(sqf(d[0]) + sqf(d[1]) + sqf(d[2])));
        if (a == 0) return res;
        cnt = (active_count > NSPH) ? NSPH : active_count;
        for (int i = 0; i < cnt; i++)
        begin
            oc[0] = clamp32(o[0] - tbl_cx[i]);
            oc[1] = clamp32(o[1] - tbl_cy[i]);
            oc[2] = clamp32(o[2] - tbl_cz[i]);
            h = clamp32(fshr(d[0] * oc[0]) + fshr(d[1] * oc[1]) + fshr(d[2] * oc[2]));
            c = clamp32(longint'(sqf(oc[0]) + sqf(oc[1]) + sqf(oc[2]))
                        - longint'((tbl_r[i] * tbl_r[i]) >> FB));
            disc = h * h - a * c;
            if (disc < 0) continue;
            s = root64(disc);
            num = -h - longint'(s);
            if (num < 0) continue;
            t = (longint'(num) << FB) / a;
            if (t > 64'h7fffffff) t = 64'h7fffffff;
            if (any && t > best_t) continue;
            best_t = t;
            best_i = i;
            any = 1;
        end
        if (!any || best_t == 0) return res;
        cen[0] = tbl_cx[best_i]; cen[1] = tbl_cy[best_i]; cen[2] = tbl_cz[best_i];
        for (int k = 0; k < 3; k++)
        begin
            pos[k] = clamp32(fshr(longint'(best_t) * d[k]) + o[k]);
            n[k] = clamp32(pos[k] - cen[k]);
        end
        len = root64(n[0] * n[0] + n[1] * n[1] + n[2] * n[2]);
        res.hit = 1;
        res.distance = best_t[30:0];
        res.pos_x = pos[0][31:0];
        res.pos_y = pos[1][31:0];
        res.pos_z = pos[2][31:0];
        res.object_index = best_i[3:0];
        for (int k = 0; k < 3; k++)
        begin
            longint nv;
            nv = 0;
            if (len != 0)
            begin
                mag = (n[k] < 0) ? -n[k] : n[k];
                q = (mag << FB) / len;
                if (q > 131071) q = 131071;
                nv = (n[k] < 0) ? -longint'(q) : longint'(q);
            end
            if (k == 0) res.normal_x = nv[17:0];
            else if (k == 1) res.normal_y = nv[17:0];
            else res.normal_z = nv[17:0];
        end
        return res;
    endfunction

    // driver
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (push && !full)
            begin
                if (cur.op == OP_LOAD)
                begin
                    tbl_cx[cur.idx] = $signed(cur.c0);
                    tbl_cy[cur.idx] = $signed(cur.c1);
                    tbl_cz[cur.idx] = $signed(cur.c2);
                    tbl_r[cur.idx]  = longint'(cur.rad);
                end
                else
                begin
                    hit_expect.push_back(trace_ray(cur));
                    traces++;
                end
            end
            if (!push || !full)
            begin
                if (pending.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    cur <= pending.pop_front();
                    push <= 1;
                end
                else
                    push <= 0;
            end
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            res_t got, exp;
            got = '{hit, distance, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z,
                    object_index};
            if (hit_expect.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("ERROR: unexpected result %p", got);
            end
            else
            begin
                exp = hit_expect.pop_front();
                hits_seen += got.hit;
                if (got !== exp)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("ERROR: result mismatch\n  exp %p\n  got %p", exp, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > 64'd3000000)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $signed($urandom_range(40 << FB)) - (20 << FB);
        endcase
    endfunction

    function automatic xact_t mk_load(int slot, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic [31:0] r);
        xact_t t;
        t = '{default: '0};
        t.op = OP_LOAD; t.idx = 4'(slot); t.c0 = x; t.c1 = y; t.c2 = z; t.rad = r[30:0];
        t.o0 = $urandom; t.d0 = $urandom;
        return t;
    endfunction

    function automatic xact_t mk_trace(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                       logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        xact_t t;
        t = '{default: '0};
        t.op = OP_TRACE; t.idx = 4'($urandom); t.c0 = $urandom; t.rad = 31'($urandom);
        t.o0 = ox; t.o1 = oy; t.o2 = oz; t.d0 = dx; t.d1 = dy; t.d2 = dz;
        return t;
    endfunction

    function automatic xact_t rnd_load(int slot);
        logic [30:0] r;
        r = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(6 << FB));
        return mk_load(slot, rnd_coord(), rnd_coord(), rnd_coord(), {1'b0, r});
    endfunction

    function automatic xact_t rnd_trace();
        logic [31:0] dv[3];
        for (int k = 0; k < 3; k++)
            case ($urandom_range(7))
                0: dv[k] = $urandom;
                1: dv[k] = 0;
                2: dv[k] = $urandom_range(255);
                default: dv[k] = $signed($urandom_range(2 << FB)) - (1 << FB);
            endcase
        return mk_trace(rnd_coord(), rnd_coord(), rnd_coord(), dv[0], dv[1], dv[2]);
    endfunction

    task automatic drain();
        while (pending.size() != 0 || push) @(posedge clk);
        while (hit_expect.size() > 0) @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    task automatic set_count(int n);
        @(posedge clk);
        cfg_wr_en <= 1;
        cfg_wr_data <= 5'(n);
        @(posedge clk);
        cfg_wr_en <= 0;
        active_count = n;
    endtask

    initial
    begin
        int counts[5];
        counts = '{16, 3, 31, 1, 0};
        repeat (7) @(posedge clk);
        rst_n <= 1;
        // fill every slot before anything is traced
        for (int i = 0; i < NSPH; i++)
            pending.push_back(rnd_load(i));
        drain();
        set_count(4);
        // directed: spheres on the z axis, ties, extremes, zero and tiny directions
        pending.push_back(mk_load(0, 0, 0, 10 << FB, 1 << FB));
        pending.push_back(mk_load(1, 0, 0, 10 << FB, 1 << FB));
        pending.push_back(mk_load(2, 0, 0, 5 << FB, 2 << FB));
        pending.push_back(mk_load(3, 32'h7fffffff, 32'h80000000, 0, 32'h7fffffff));
        pending.push_back(mk_trace(0, 0, 0, 0, 0, 1 << FB));
        pending.push_back(mk_trace(0, 0, 0, 0, 0, 0));
        pending.push_back(mk_trace(0, 0, 0, 1, 1, 1));
        pending.push_back(mk_trace(0, 0, 0, 0, 0, -(1 << FB)));
        pending.push_back(mk_trace(0, 0, 20 << FB, 0, 0, -(1 << FB)));
        pending.push_back(mk_trace(0, 0, 5 << FB, 0, 0, 1 << FB));
        pending.push_back(mk_trace(0, 0, 3 << FB, 0, 0, 1 << FB));
        pending.push_back(mk_trace(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                   32'h80000000, 32'h80000000, 32'h80000000));
        pending.push_back(mk_trace(32'h80000000, 32'h80000000, 32'h80000000,
                                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending.push_back(mk_trace(0, 50 << FB, 0, 1 << FB, 0, 0));
        drain();
        for (int ph = 0; ph < 5; ph++)
        begin
            set_count(counts[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (int n = 0; n < 125; n++)
                if ($urandom_range(4) == 0)
                    pending.push_back(rnd_load($urandom_range(NSPH - 1)));
                else
                    pending.push_back(rnd_trace());
            drain();
        end
        $display("Covered %0d traces (%0d hits) over sphere counts 0..31 and four",
                 traces, hits_seen);
        $display("handshake pressure mixes, %0d cycles", cycles);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
